>>> rtl/lthi_pkg.sv
package lthi_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [31:0] DJB_SEED    = 32'd5381;

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    typedef enum logic [2:0] {
        CLS_PLAIN    = 3'd0,
        CLS_LINE_END = 3'd1,
        CLS_MARK     = 3'd2,
        CLS_TAB      = 3'd3,
        CLS_BLANK    = 3'd4
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        byte_class_t cls;
        logic [31:0] offset;
    } entry_t;

endpackage

>>> rtl/line_token_hash_indexer.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+---------------------------------------
// in       | in        | in_valid / in_stall  | data_byte
// out      | out       | out_valid / out_stall| line_number, token_offset, weak_hash,
//          |           |                      | djb2_hash
//
// One byte per cycle unless stalled; a request reaches the back end via a 4-entry queue.
// A line end is written into a queue slot; its record is then registered at the output.
// The back end stalls only on a line end with a pending record while the output is full;
// in_stall rises when the queue fills. Reset clears all control state asynchronously.
module line_token_hash_indexer #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] line_number,
    output logic [31:0] token_offset,
    output logic [31:0] weak_hash,
    output logic [31:0] djb2_hash
);
    import lthi_pkg::*;

    logic   push;
    logic   pop;
    logic   q_valid;
    logic   q_full;
    entry_t push_entry;
    entry_t head;

    lthi_front #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    lthi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .head       (head)
    );

    lthi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_number  (line_number),
        .token_offset (token_offset),
        .weak_hash    (weak_hash),
        .djb2_hash    (djb2_hash)
    );

endmodule

>>> rtl/lthi_front.sv
module lthi_front #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      data_byte,
    input  logic            q_full,
    output logic            push,
    output lthi_pkg::entry_t push_entry
);
    import lthi_pkg::*;

    logic [POSITION_WIDTH-1:0]    position_reg, position_next;
    logic                         cr_pending_reg, cr_pending_next;
    logic [POSITION_WIDTH+31:0]   pos_ext;
    logic                         accept;
    logic                         swallow;
    byte_class_t                  cls;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign swallow  = cr_pending_reg && (data_byte == CH_LF);
    assign pos_ext  = {32'b0, position_reg};

    always_comb
    begin
        unique case (data_byte) inside
            CH_LF, CH_CR:                 cls = CLS_LINE_END;
            CH_HASH, CH_LBRACE, CH_RBRACE: cls = CLS_MARK;
            CH_TAB:                       cls = CLS_TAB;
            CH_NUL, CH_SPACE:             cls = CLS_BLANK;
            default:                      cls = CLS_PLAIN;
        endcase
    end

    always_comb
    begin
        position_next   = position_reg;
        cr_pending_next = cr_pending_reg;
        if (accept)
        begin
            position_next   = position_reg + 1'b1;
            cr_pending_next = !swallow && (data_byte == CH_CR);
        end
    end

    assign push                 = accept && !swallow;
    assign push_entry.data_byte = data_byte;
    assign push_entry.cls       = cls;
    assign push_entry.offset    = pos_ext[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            cr_pending_reg <= 1'b0;
        end
        else
        begin
            position_reg   <= position_next;
            cr_pending_reg <= cr_pending_next;
        end
    end

endmodule

>>> rtl/lthi_queue.sv
module lthi_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lthi_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             q_valid,
    output logic             q_full,
    output lthi_pkg::entry_t head
);
    import lthi_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head    = slots_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/lthi_back.sv
module lthi_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  lthi_pkg::entry_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [31:0]      line_number,
    output logic [31:0]      token_offset,
    output logic [31:0]      weak_hash,
    output logic [31:0]      djb2_hash
);
    import lthi_pkg::*;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_TOKEN = 3'b010,
        PH_SKIP  = 3'b100
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic         token_seen_reg, token_seen_next;
    logic [31:0]  line_count_reg, line_count_next;
    logic [31:0]  start_reg, start_next;
    logic [15:0]  length_reg, length_next;
    logic [15:0]  sum_reg, sum_next;
    logic [31:0]  djb_reg, djb_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  line_number_reg, token_offset_reg, weak_hash_reg, djb2_hash_reg;

    logic         is_end;
    logic         emit;
    logic         out_free;
    logic [31:0]  sext;
    logic [31:0]  djb_base;
    logic [31:0]  djb_step;

    assign is_end   = (head.cls == CLS_LINE_END);
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = q_valid && (!is_end || !token_seen_reg || out_free);
    assign emit     = pop && is_end && token_seen_reg;
    assign sext     = {{24{head.data_byte[7]}}, head.data_byte};
    assign djb_base = (phase_reg == PH_START) ? DJB_SEED : djb_reg;
    assign djb_step = (djb_base << 5) + djb_base + sext;

    always_comb
    begin
        phase_next      = phase_reg;
        token_seen_next = token_seen_reg;
        line_count_next = line_count_reg;
        start_next      = start_reg;
        length_next     = length_reg;
        sum_next        = sum_reg;
        djb_next        = djb_reg;
        if (pop)
        begin
            if (is_end)
            begin
                line_count_next = line_count_reg + 1'b1;
                token_seen_next = 1'b0;
                phase_next      = PH_START;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (head.cls == CLS_MARK || head.cls == CLS_TAB)
                            phase_next = PH_SKIP;
                        else
                        begin
                            start_next      = head.offset;
                            length_next     = 16'd1;
                            sum_next        = sext[15:0];
                            djb_next        = djb_step;
                            token_seen_next = 1'b1;
                            phase_next      = PH_TOKEN;
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (head.cls == CLS_TAB || head.cls == CLS_BLANK)
                            phase_next = PH_SKIP;
                        else
                        begin
                            length_next = length_reg + 1'b1;
                            sum_next    = sum_reg + sext[15:0];
                            djb_next    = djb_step;
                        end
                    end
                    PH_SKIP:
                        phase_next = PH_SKIP;
                    default:
                        phase_next = PH_START;
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            line_number_reg  <= line_count_reg + 1'b1;
            token_offset_reg <= start_reg;
            weak_hash_reg    <= {length_reg, sum_reg};
            djb2_hash_reg    <= djb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            token_seen_reg <= 1'b0;
            line_count_reg <= '0;
            start_reg      <= '0;
            length_reg     <= '0;
            sum_reg        <= '0;
            djb_reg        <= DJB_SEED;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            token_seen_reg <= token_seen_next;
            line_count_reg <= line_count_next;
            start_reg      <= start_next;
            length_reg     <= length_next;
            sum_reg        <= sum_next;
            djb_reg        <= djb_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_number  = line_number_reg;
    assign token_offset = token_offset_reg;
    assign weak_hash    = weak_hash_reg;
    assign djb2_hash    = djb2_hash_reg;

endmodule

>>> rtl/lthi_checker.sv
module lthi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] line_number,
    input logic [31:0] token_offset,
    input logic [31:0] weak_hash,
    input logic [31:0] djb2_hash
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("record dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(line_number) && $stable(token_offset)
            && $stable(weak_hash) && $stable(djb2_hash))
        else $error("stalled record changed");

    a_reset_empty_out: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("record present right after reset");

    a_reset_ready: assert property (@(posedge clk)
        !rst_n |=> !in_stall)
        else $error("input stalled right after reset");

endmodule

bind line_token_hash_indexer lthi_checker u_lthi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_number  (line_number),
    .token_offset (token_offset),
    .weak_hash    (weak_hash),
    .djb2_hash    (djb2_hash)
);

>>> tb/sv/line_token_hash_indexer_tb.sv
module line_token_hash_indexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lthi_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 100000;

    typedef enum logic [1:0] {
        SCAN_LINE_START,
        SCAN_TOKEN,
        SCAN_SKIP
    } scan_phase_t;

    typedef struct packed {
        logic [31:0] line_number;
        logic [31:0] token_offset;
        logic [31:0] weak_hash;
        logic [31:0] djb2_hash;
    } token_rec_t;

    class token_index_book;
        scan_phase_t phase;
        bit          cr_seen;
        bit          have_token;
        logic [31:0] lines;
        logic [31:0] position;
        logic [31:0] tok_start;
        logic [15:0] tok_len;
        logic [15:0] tok_sum;
        logic [31:0] djb;
        token_rec_t  pending[$];
        int          errors;
        int          checked;

        function new();
            phase      = SCAN_LINE_START;
            cr_seen    = 1'b0;
            have_token = 1'b0;
            lines      = '0;
            position   = '0;
            tok_start  = '0;
            tok_len    = '0;
            tok_sum    = '0;
            djb        = DJB_SEED;
            errors     = 0;
            checked    = 0;
        endfunction

        function void fold(logic [31:0] ext);
            tok_sum = tok_sum + ext[15:0];
            tok_len = tok_len + 16'd1;
            djb     = (djb << 5) + djb + ext;
        endfunction

        function void take_byte(logic [7:0] b);
            logic [31:0] here;
            logic [31:0] ext;
            token_rec_t  rec;
            here     = position;
            position = position + 32'd1;
            ext      = {{24{b[7]}}, b};
            if (cr_seen && b == CH_LF)
            begin
                cr_seen = 1'b0;
                return;
            end
            cr_seen = 1'b0;
            if (b == CH_LF || b == CH_CR)
            begin
                cr_seen = (b == CH_CR);
                lines   = lines + 32'd1;
                if (have_token)
                begin
                    rec.line_number  = lines;
                    rec.token_offset = tok_start;
                    rec.weak_hash    = {tok_len, tok_sum};
                    rec.djb2_hash    = djb;
                    pending.push_back(rec);
                    have_token = 1'b0;
                end
                phase = SCAN_LINE_START;
                return;
            end
            case (phase)
                SCAN_LINE_START:
                begin
                    if (b == CH_HASH || b == CH_LBRACE || b == CH_RBRACE || b == CH_TAB)
                    begin
                        phase = SCAN_SKIP;
                    end
                    else
                    begin
                        tok_start  = here;
                        tok_len    = '0;
                        tok_sum    = '0;
                        djb        = DJB_SEED;
                        fold(ext);
                        have_token = 1'b1;
                        phase      = SCAN_TOKEN;
                    end
                end
                SCAN_TOKEN:
                begin
                    if (b == CH_NUL || b == CH_TAB || b == CH_SPACE)
                        phase = SCAN_SKIP;
                    else
                        fold(ext);
                end
                default:
                begin
                    phase = SCAN_SKIP;
                end
            endcase
        endfunction

        function void check_record(token_rec_t got);
            token_rec_t want;
            if (pending.size() == 0)
            begin
                $error("record with no request behind it: line_number %0d", got.line_number);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.line_number !== want.line_number)
            begin
                $error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
                errors++;
            end
            if (got.token_offset !== want.token_offset)
            begin
                $error("token_offset: expected %0d, got %0d",
                       want.token_offset, got.token_offset);
                errors++;
            end
            if (got.weak_hash !== want.weak_hash)
            begin
                $error("weak_hash: expected %h, got %h", want.weak_hash, got.weak_hash);
                errors++;
            end
            if (got.djb2_hash !== want.djb2_hash)
            begin
                $error("djb2_hash: expected %h, got %h", want.djb2_hash, got.djb2_hash);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] line_number;
    logic [31:0] token_offset;
    logic [31:0] weak_hash;
    logic [31:0] djb2_hash;

    token_index_book book = new();
    token_rec_t      seen_rec;
    bit              idle_off    = 1'b0;
    int unsigned     stall_left  = 0;
    int unsigned     cycle_count = 0;
    int              bytes_sent  = 0;

    line_token_hash_indexer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_number  (line_number),
        .token_offset (token_offset),
        .weak_hash    (weak_hash),
        .djb2_hash    (djb2_hash)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d records outstanding",
                     cycle_count, book.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            book.take_byte(data_byte);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen_rec.line_number  = line_number;
                seen_rec.token_offset = token_offset;
                seen_rec.weak_hash    = weak_hash;
                seen_rec.djb2_hash    = djb2_hash;
                book.check_record(seen_rec);
                stall_left = idle_off ? 0 : $urandom_range(0, 5);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    // bytes that stay inside a token
    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        do
        begin
            if ($urandom_range(0, 1) == 0)
                b = 8'($urandom_range(8'h21, 8'h7e));
            else
                b = 8'($urandom_range(0, 255));
        end
        while (b == CH_LF || b == CH_CR || b == CH_NUL || b == CH_TAB || b == CH_SPACE);
        return b;
    endfunction

    function automatic logic [7:0] start_byte();
        logic [7:0] b;
        do
            b = token_byte();
        while (b == CH_HASH || b == CH_LBRACE || b == CH_RBRACE);
        return b;
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_LF || b == CH_CR);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line_end();
        case ($urandom_range(0, 5))
            0, 1:
                send_byte(CH_LF);
            2:
                send_byte(CH_CR);
            3, 4:
            begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            default:
            begin
                send_byte(CH_CR);
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
        endcase
    endtask

    task automatic send_token_body();
        logic [7:0] delim;
        repeat ($urandom_range(0, 12)) send_byte(token_byte());
        if ($urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 2))
                0:       delim = CH_NUL;
                1:       delim = CH_TAB;
                default: delim = CH_SPACE;
            endcase
            send_byte(delim);
            repeat ($urandom_range(0, 6)) send_byte(junk_byte());
        end
    endtask

    task automatic send_random_line();
        logic [7:0] lead;
        idle_off = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                send_byte(start_byte());
                send_token_body();
            end
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       lead = CH_HASH;
                    1:       lead = CH_LBRACE;
                    2:       lead = CH_RBRACE;
                    default: lead = CH_TAB;
                endcase
                send_byte(lead);
                repeat ($urandom_range(0, 8)) send_byte(junk_byte());
            end
            7:
            begin
            end
            8:
            begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end
            default:
            begin
                send_byte(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_NUL);
                send_token_body();
            end
        endcase
        send_line_end();
    endtask

    initial
    begin
        logic [7:0] opening[];
        int         random_start;

        opening = '{8'h61, CH_LF,
                    CH_HASH, 8'h78, CH_CR,
                    8'hff, 8'h80, CH_SPACE, 8'h71, CH_CR, CH_LF,
                    CH_LF,
                    CH_SPACE, 8'h7f, CH_TAB, CH_CR,
                    CH_LBRACE, CH_LF, CH_RBRACE, CH_LF, CH_TAB, 8'h41, CH_LF,
                    CH_NUL, 8'h62, CH_NUL, 8'h63, CH_LF,
                    CH_CR, CH_CR, CH_LF};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_byte(opening[i]);

        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_ITEMS)
            send_random_line();

        repeat (4) send_random_line();

        // last line left open: must not produce a record
        send_byte(start_byte());
        repeat ($urandom_range(1, 5)) send_byte(token_byte());
        in_valid <= 1'b0;

        while (book.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("streamed %0d bytes, checked %0d token records in %0d cycles",
                 bytes_sent, book.checked, cycle_count);
        $display("mixed LF, CR and CR-LF endings, skipped lines, blank starts, open last line");
        if (book.errors == 0 && book.pending.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/lthi_pkg.sv
rtl/lthi_front.sv
rtl/lthi_queue.sv
rtl/lthi_back.sv
rtl/line_token_hash_indexer.sv
rtl/lthi_checker.sv
tb/sv/line_token_hash_indexer_tb.sv
